// ===== hw/rtl/ntc_pkg.sv =====
// Shared types, type codes and helper functions of the numeric type converter.
// No dependencies; the stage modules, the top level and the bench use this package.
package ntc_pkg;

    localparam logic [3:0] TY_U8  = 4'd0;
    localparam logic [3:0] TY_I8  = 4'd1;
    localparam logic [3:0] TY_U16 = 4'd2;
    localparam logic [3:0] TY_I16 = 4'd3;
    localparam logic [3:0] TY_U32 = 4'd4;
    localparam logic [3:0] TY_I32 = 4'd5;
    localparam logic [3:0] TY_F32 = 4'd6;
    localparam logic [3:0] TY_I64 = 4'd7;
    localparam logic [3:0] TY_U64 = 4'd8;
    localparam logic [3:0] TY_F64 = 4'd9;

    localparam int EXP_W = 13;

    typedef enum logic [1:0] {
        OP_DIRECT,
        OP_TO_FLOAT,
        OP_TO_INT
    } t_op;

    // One pipeline slot. The sig and word fields change meaning per stage:
    // sig is the raw significand, then normalized, then the kept bits or the
    // integer magnitude; word is the finished result or the exponent base.
    typedef struct packed {
        t_op                     op;
        logic                    bad;
        logic [3:0]              dest;
        logic                    sign;
        logic [63:0]             sig;
        logic signed [EXP_W-1:0] expo;
        logic [63:0]             word;
        logic                    rnd;
        logic                    ovf;
        logic                    under;
    } t_work;

    function automatic logic [63:0] f_mask(input logic [3:0] code);
        logic [63:0] m;
        unique case (code)
            TY_U8, TY_I8:                  m = 64'h0000_0000_0000_00FF;
            TY_U16, TY_I16:                m = 64'h0000_0000_0000_FFFF;
            TY_U32, TY_I32, TY_F32:        m = 64'h0000_0000_FFFF_FFFF;
            default:                       m = '1;
        endcase
        return m;
    endfunction

    function automatic logic f_is_float(input logic [3:0] code);
        return (code == TY_F32) || (code == TY_F64);
    endfunction

    function automatic logic f_is_signed(input logic [3:0] code);
        return (code == TY_I8) || (code == TY_I16) || (code == TY_I32) || (code == TY_I64);
    endfunction

endpackage

// ===== hw/rtl/ntc_if.sv =====
// Valid/ready channel interfaces of the numeric type converter.
// No dependencies.
interface ntc_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  src_type;
    logic [3:0]  dest_type;
    logic [63:0] value_bits;
    modport source (output valid, src_type, dest_type, value_bits, input ready);
    modport sink   (input valid, src_type, dest_type, value_bits, output ready);
endinterface

interface ntc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;
    logic        bad_request;
    modport source (output valid, result_bits, bad_request, input ready);
    modport sink   (input valid, result_bits, bad_request, output ready);
endinterface

// ===== hw/rtl/ntc_decode.sv =====
// Stage 1: type checks, integer work and float field decode.
// Depends on ntc_pkg.
module ntc_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [3:0]     i_src,
    input  logic [3:0]     i_dest,
    input  logic [63:0]    i_value,
    output logic           o_valid,
    input  logic           i_ready,
    output ntc_pkg::t_work o_data
);
    logic           r_valid;
    ntc_pkg::t_work r_data;
    ntc_pkg::t_work n_data;

    logic [63:0] ext, mag, smask;
    logic        neg, fsign, f64s, einf, ezero, fnan;
    logic [10:0] ebits;
    logic [51:0] frac;
    logic [63:0] sgnw, infw, pay;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        smask = ntc_pkg::f_mask(i_src);
        ext   = i_value & smask;
        neg   = ntc_pkg::f_is_signed(i_src) && (|(ext & ~(smask >> 1)));
        if (neg) begin
            ext = ext | ~smask;
        end
        mag = neg ? (64'd0 - ext) : ext;

        f64s = (i_src == ntc_pkg::TY_F64);
        if (f64s) begin
            fsign = i_value[63];
            ebits = i_value[62:52];
            frac  = i_value[51:0];
            einf  = (i_value[62:52] == 11'h7FF);
        end else begin
            fsign = i_value[31];
            ebits = {3'b000, i_value[30:23]};
            frac  = {29'd0, i_value[22:0]};
            einf  = (i_value[30:23] == 8'hFF);
        end
        ezero = (ebits == 11'd0) && (frac == 52'd0);
        fnan  = einf && (frac != 52'd0);

        if (i_dest == ntc_pkg::TY_F64) begin
            sgnw = {fsign, 63'd0};
            infw = {1'b0, 11'h7FF, 52'd0};
            pay  = f64s ? {12'd0, frac} : {12'd0, frac[22:0], 29'd0};
            pay  = pay | (64'd1 << 51);
        end else begin
            sgnw = {32'd0, fsign, 31'd0};
            infw = {33'd0, 8'hFF, 23'd0};
            pay  = f64s ? {41'd0, frac[51:29]} : {41'd0, frac[22:0]};
            pay  = pay | (64'd1 << 22);
        end

        n_data       = '0;
        n_data.op    = ntc_pkg::OP_DIRECT;
        n_data.dest  = i_dest;
        if (i_src > ntc_pkg::TY_F64 || i_dest > ntc_pkg::TY_F64) begin
            n_data.bad = 1'b1;
        end else if (i_src == i_dest) begin
            n_data.word = i_value;
        end else if (!ntc_pkg::f_is_float(i_src)) begin
            if (!ntc_pkg::f_is_float(i_dest)) begin
                n_data.word = ext & ntc_pkg::f_mask(i_dest);
            end else if (mag != 64'd0) begin
                n_data.op   = ntc_pkg::OP_TO_FLOAT;
                n_data.sign = neg;
                n_data.sig  = mag;
                n_data.expo = ntc_pkg::EXP_W'(63);
            end
        end else begin
            n_data.sign = fsign;
            if (fnan) begin
                n_data.word = ntc_pkg::f_is_float(i_dest) ? (sgnw | infw | pay) : 64'd0;
            end else if (einf) begin
                if (ntc_pkg::f_is_float(i_dest)) begin
                    n_data.word = sgnw | infw;
                end else begin
                    n_data.op  = ntc_pkg::OP_TO_INT;
                    n_data.ovf = 1'b1;
                end
            end else if (ezero) begin
                n_data.word = ntc_pkg::f_is_float(i_dest) ? sgnw : 64'd0;
            end else begin
                n_data.op  = ntc_pkg::f_is_float(i_dest) ? ntc_pkg::OP_TO_FLOAT
                                                        : ntc_pkg::OP_TO_INT;
                // Significand with the hidden bit; subnormals use exponent one.
                if (f64s) begin
                    n_data.sig  = (ebits != 11'd0) ? {11'd0, 1'b1, frac} : {12'd0, frac};
                    n_data.expo = $signed({2'b00, (ebits != 11'd0) ? ebits : 11'd1})
                                  - ntc_pkg::EXP_W'(1012);
                end else begin
                    n_data.sig  = (ebits != 11'd0) ? {40'd0, 1'b1, frac[22:0]}
                                                   : {41'd0, frac[22:0]};
                    n_data.expo = $signed({2'b00, (ebits != 11'd0) ? ebits : 11'd1})
                                  - ntc_pkg::EXP_W'(87);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ===== hw/rtl/ntc_normalize.sv =====
// Stage 2: leading-zero count and left shift of the significand.
// Depends on ntc_pkg.
module ntc_normalize (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ntc_pkg::t_work i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output ntc_pkg::t_work o_data
);
    logic           r_valid;
    ntc_pkg::t_work r_data;
    ntc_pkg::t_work n_data;
    logic [5:0]     lz;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        lz = 6'd63;
        for (int i = 0; i < 64; i++) begin
            if (i_data.sig[i]) begin
                lz = 6'(63 - i);
            end
        end
        n_data      = i_data;
        n_data.sig  = i_data.sig << lz;
        n_data.expo = i_data.expo - $signed({7'd0, lz});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ===== hw/rtl/ntc_round.sv =====
// Stage 3: right alignment for the destination, guard and sticky rounding
// decision, and integer magnitude extraction. Depends on ntc_pkg.
module ntc_round (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ntc_pkg::t_work i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output ntc_pkg::t_work o_data
);
    logic           r_valid;
    ntc_pkg::t_work r_data;
    ntc_pkg::t_work n_data;

    logic                          d64, sub;
    logic signed [ntc_pkg::EXP_W-1:0] bias, emin, sh;
    logic [6:0]                    shift;
    logic [127:0]                  aligned;
    logic [5:0]                    rsh;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        d64     = (i_data.dest == ntc_pkg::TY_F64);
        bias    = d64 ? ntc_pkg::EXP_W'(1023) : ntc_pkg::EXP_W'(127);
        emin    = ntc_pkg::EXP_W'(1) - bias;
        sub     = i_data.expo < emin;
        sh      = (d64 ? ntc_pkg::EXP_W'(11) : ntc_pkg::EXP_W'(40))
                  + (sub ? (emin - i_data.expo) : ntc_pkg::EXP_W'(0));
        shift   = sh[6:0];
        aligned = {i_data.sig, 64'd0} >> shift;
        rsh     = 6'(7'd63 - {1'b0, i_data.expo[5:0]});
        n_data  = i_data;
        if (i_data.op == ntc_pkg::OP_TO_FLOAT) begin
            if (i_data.expo > bias) begin
                n_data.ovf = 1'b1;
            end else if (sh > ntc_pkg::EXP_W'(64)) begin
                n_data.under = 1'b1;
            end else begin
                n_data.sig  = aligned[127:64];
                n_data.rnd  = aligned[63] && ((|aligned[62:0]) || aligned[64]);
                n_data.word = sub ? 64'd0
                              : (64'($unsigned(i_data.expo + bias - ntc_pkg::EXP_W'(1)))
                                 << (d64 ? 52 : 23));
            end
        end else if (i_data.op == ntc_pkg::OP_TO_INT && !i_data.ovf) begin
            if (i_data.expo >= ntc_pkg::EXP_W'(64)) begin
                n_data.ovf = 1'b1;
            end else if (i_data.expo >= ntc_pkg::EXP_W'(0)) begin
                n_data.sig = i_data.sig >> rsh;
            end else begin
                n_data.sig = 64'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ===== hw/rtl/ntc_pack.sv =====
// Stage 4: rounding increment, overflow clamp, integer saturation and final
// field assembly into the output register. Depends on ntc_pkg.
module ntc_pack (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ntc_pkg::t_work i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [63:0]    o_result,
    output logic           o_bad
);
    logic        r_valid;
    logic [63:0] r_result;
    logic        r_bad;
    logic [63:0] n_result;

    logic        d64;
    logic [63:0] dmask, half, bits, infw, sgnw;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        d64   = (i_data.dest == ntc_pkg::TY_F64);
        dmask = ntc_pkg::f_mask(i_data.dest);
        half  = (dmask >> 1) + 64'd1;
        infw  = d64 ? {1'b0, 11'h7FF, 52'd0} : {33'd0, 8'hFF, 23'd0};
        sgnw  = d64 ? {i_data.sign, 63'd0} : {32'd0, i_data.sign, 31'd0};
        bits  = i_data.word + i_data.sig + {63'd0, i_data.rnd};
        if (i_data.under) begin
            bits = 64'd0;
        end else if (i_data.ovf || bits >= infw) begin
            bits = infw;
        end
        unique case (i_data.op)
            ntc_pkg::OP_TO_FLOAT: begin
                n_result = (sgnw | bits) & dmask;
            end
            ntc_pkg::OP_TO_INT: begin
                if (!ntc_pkg::f_is_signed(i_data.dest)) begin
                    if (i_data.sign) begin
                        n_result = 64'd0;
                    end else if (i_data.ovf || i_data.sig > dmask) begin
                        n_result = dmask;
                    end else begin
                        n_result = i_data.sig;
                    end
                end else if (i_data.sign) begin
                    if (i_data.ovf || i_data.sig > half) begin
                        n_result = half;
                    end else begin
                        n_result = (64'd0 - i_data.sig) & dmask;
                    end
                end else if (i_data.ovf || i_data.sig > half - 64'd1) begin
                    n_result = half - 64'd1;
                end else begin
                    n_result = i_data.sig;
                end
            end
            default: begin
                n_result = i_data.word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_result <= n_result;
            r_bad    <= i_data.bad;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_bad    = r_bad;
endmodule

// ===== hw/rtl/numeric_type_converter_top.sv =====
// Top level of the numeric type converter: four pipeline stages in a row.
// Depends on ntc_pkg, ntc_if, ntc_decode, ntc_normalize, ntc_round, ntc_pack.
//
// Usage: an input transaction on i_in carries a source type code, a destination
// type code and a 64-bit value word. Each input transaction yields exactly one
// output transaction on o_out with the converted value, right-aligned and zero
// above the destination width when the types differ, and a bad_request flag for
// invalid type codes. Integer narrowing truncates, widening sign- or
// zero-extends; conversions to float round to nearest even; float to integer
// truncates and saturates. The decode register loads at the accepting edge,
// and the result then moves through the normalize, round and pack registers
// in turn; o_out is valid as soon as the pack register holds the result.
// Throughput is one transaction per cycle without stalls: each stage holds its
// own valid bit and a stage loads whenever it is empty or its successor takes
// its contents, so bubbles close up and a new item enters while older ones are
// in flight. The rounding stage, with its 128-bit alignment shifter and
// rounding decision, holds the deepest logic between registers.
// When the receiver holds o_out.ready low the result stays in the output
// register and the stages behind it fill up; once all four are full i_in.ready
// goes low. Nothing is dropped or repeated across a stall.
// Synchronous active-low reset empties the pipeline; the block keeps no other
// state, so it is ready for a transaction as soon as reset is released.
module numeric_type_converter_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ntc_in_if.sink   i_in,
    ntc_out_if.source o_out
);
    logic           s1_valid, s2_valid, s3_valid;
    logic           s2_ready, s3_ready, s4_ready;
    ntc_pkg::t_work s1_data, s2_data, s3_data;

    // Decode: classify the type pair and handle the direct cases at once.
    ntc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_src   (i_in.src_type),
        .i_dest  (i_in.dest_type),
        .i_value (i_in.value_bits),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_data  (s1_data)
    );

    // Normalize: bring the leading one of the significand to bit 63.
    ntc_normalize u_normalize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s2_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s3_ready),
        .o_data  (s2_data)
    );

    // Round: align to the destination format and decide the increment.
    ntc_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s3_ready),
        .i_data  (s2_data),
        .o_valid (s3_valid),
        .i_ready (s4_ready),
        .o_data  (s3_data)
    );

    // Pack: apply the increment, clamp, saturate and register the result.
    ntc_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s3_valid),
        .o_ready  (s4_ready),
        .i_data   (s3_data),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (o_out.result_bits),
        .o_bad    (o_out.bad_request)
    );
endmodule

// ===== dv/ntc_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench constants of the numeric type converter bench.
// No dependencies.
package ntc_tb_pkg;
    localparam int WATCHDOG_CYCLES = 20000;
endpackage

// ===== dv/numeric_type_converter_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for numeric_type_converter_top: a directed table then
// random conversions, each result compared with a bit-exact conversion predictor.
// Depends on ntc_pkg, ntc_if, ntc_tb_pkg and the converter RTL.
module numeric_type_converter_top_tb;

    typedef struct {
        logic [3:0]  src;
        logic [3:0]  dst;
        logic [63:0] val;
        logic        known;     // Expected result typed in by hand.
        logic [63:0] res;
        logic        bad;
    } t_row;

    typedef struct {
        logic [63:0] res;
        logic        bad;
    } t_conv;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #2 i_clk = ~i_clk;

    ntc_in_if  in_ch();
    ntc_out_if out_ch();

    numeric_type_converter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_conv pending_q[$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    bit    timed_out = 0;
    bit    stim_done = 0;
    bit    long_hold = 0;

    // Width in bits of every valid type code.
    function automatic int width_of(logic [3:0] c);
        case (c)
            ntc_pkg::TY_U8, ntc_pkg::TY_I8:   return 8;
            ntc_pkg::TY_U16, ntc_pkg::TY_I16: return 16;
            ntc_pkg::TY_U32, ntc_pkg::TY_I32, ntc_pkg::TY_F32: return 32;
            default:        return 64;
        endcase
    endfunction

    function automatic logic [63:0] lmask(int w);
        return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic int clz64(logic [63:0] x);
        int n;
        n = 0;
        while (n < 63 && !x[63]) begin
            x = x << 1;
            n++;
        end
        return n;
    endfunction

    // Rounds sign * m/2^63 * 2^e to nearest even in a float of fb/xb bits.
    function automatic logic [63:0] round_pack(logic sgn, logic [63:0] m, int e,
                                               int fb, int xb);
        logic [63:0] sbit, inf, kept, rem, half, bits;
        int bias, emin, sh;
        logic sub;
        sbit = {63'd0, sgn} << (fb + xb);
        inf = lmask(xb) << fb;
        bias = (1 << (xb - 1)) - 1;
        emin = 1 - bias;
        sh = 63 - fb;
        sub = e < emin;
        if (e > bias) return sbit | inf;
        if (sub) sh += emin - e;
        if (sh > 64) return sbit;
        if (sh == 64) begin
            kept = 64'd0;
            rem = m;
            half = 64'd1 << 63;
        end else begin
            kept = m >> sh;
            rem = m & lmask(sh);
            half = 64'd1 << (sh - 1);
        end
        if (rem > half || (rem == half && kept[0])) kept++;
        if (sub) bits = kept;
        else bits = (64'(e + bias - 1) << fb) + kept;
        if (bits >= inf) bits = inf;
        return sbit | bits;
    endfunction

    function automatic t_conv convert(logic [3:0] s, logic [3:0] d, logic [63:0] v);
        t_conv r;
        int sw, dw, sfb, sxb, dfb, dxb, bias, q, lz, e;
        logic [63:0] ext, mag, allx, ebits, frac, sig, m, hf, out, pay;
        logic neg, sgn, big;
        int cls; // 0 zero, 1 finite, 2 inf, 3 nan
        r.res = 64'd0;
        r.bad = 1'b0;
        if (s > ntc_pkg::TY_F64 || d > ntc_pkg::TY_F64) begin
            r.bad = 1'b1;
            return r;
        end
        if (s == d) begin
            r.res = v;
            return r;
        end
        sw = width_of(s);
        dw = width_of(d);
        sfb = (sw == 32) ? 23 : 52;
        sxb = (sw == 32) ? 8 : 11;
        dfb = (dw == 32) ? 23 : 52;
        dxb = (dw == 32) ? 8 : 11;
        out = 64'd0;
        if (!ntc_pkg::f_is_float(s)) begin
            ext = v & lmask(sw);
            neg = 1'b0;
            mag = ext;
            if (ntc_pkg::f_is_signed(s) && ext[sw-1]) begin
                ext |= ~lmask(sw);
                neg = 1'b1;
                mag = -ext;
            end
            if (!ntc_pkg::f_is_float(d)) out = ext;
            else if (mag != 0) begin
                lz = clz64(mag);
                out = round_pack(neg, mag << lz, 63 - lz, dfb, dxb);
            end
        end else begin
            v = v & lmask(sw);
            allx = lmask(sxb);
            ebits = (v >> sfb) & allx;
            bias = (1 << (sxb - 1)) - 1;
            frac = v & lmask(sfb);
            sgn = v[sfb + sxb];
            m = 64'd0;
            e = 0;
            if (ebits == allx) cls = (frac != 0) ? 3 : 2;
            else if (ebits == 0 && frac == 0) cls = 0;
            else begin
                cls = 1;
                sig = (ebits != 0) ? (frac | (64'd1 << sfb)) : frac;
                q = ((ebits != 0) ? int'(ebits) : 1) - bias - sfb;
                lz = clz64(sig);
                m = sig << lz;
                e = q + 63 - lz;
            end
            if (!ntc_pkg::f_is_float(d)) begin
                big = 1'b0;
                mag = 64'd0;
                if (cls == 2) big = 1'b1;
                else if (cls == 1) begin
                    if (e >= 64) big = 1'b1;
                    else if (e >= 0) mag = m >> (63 - e);
                end
                hf = 64'd1 << (dw - 1);
                if (cls == 3) out = 64'd0;
                else if (!ntc_pkg::f_is_signed(d)) begin
                    if (sgn) out = 64'd0;
                    else if (big || mag > lmask(dw)) out = lmask(dw);
                    else out = mag;
                end else if (sgn) out = (big || mag > hf) ? hf : (-mag);
                else out = (big || mag > hf - 64'd1) ? hf - 64'd1 : mag;
            end else begin
                case (cls)
                    0: out = {63'd0, sgn} << (dfb + dxb);
                    2: out = ({63'd0, sgn} << (dfb + dxb)) | (lmask(dxb) << dfb);
                    3: begin
                        pay = (sfb > dfb) ? (frac >> (sfb - dfb)) : (frac << (dfb - sfb));
                        pay = (pay & lmask(dfb)) | (64'd1 << (dfb - 1));
                        out = ({63'd0, sgn} << (dfb + dxb)) | (lmask(dxb) << dfb) | pay;
                    end
                    default: out = round_pack(sgn, m, e, dfb, dxb);
                endcase
            end
        end
        r.res = out & lmask(dw);
        return r;
    endfunction

    // Directed rows: hand-typed expectations only where they are obvious.
    t_row dir_tbl[] = '{
        '{ntc_pkg::TY_U8,  ntc_pkg::TY_U8,  64'hFFFF_FFFF_FFFF_FFFF, 1,
          64'hFFFF_FFFF_FFFF_FFFF, 0},
        '{4'd10,  ntc_pkg::TY_U8,  64'h1234, 1, 64'h0, 1},
        '{ntc_pkg::TY_U8,  4'd15,  64'h1234, 1, 64'h0, 1},
        '{4'd15,  4'd12,  64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0, 1},
        '{ntc_pkg::TY_I8,  ntc_pkg::TY_I64, 64'h80, 1, 64'hFFFF_FFFF_FFFF_FF80, 0},
        '{ntc_pkg::TY_U8,  ntc_pkg::TY_I64, 64'hFF, 1, 64'hFF, 0},
        '{ntc_pkg::TY_U64, ntc_pkg::TY_U8,  64'hFFFF_FFFF_FFFF_FF7F, 1, 64'h7F, 0},
        '{ntc_pkg::TY_I32, ntc_pkg::TY_F32, 64'h0, 1, 64'h0, 0},
        '{ntc_pkg::TY_F32, ntc_pkg::TY_I32, 64'h7FC0_0000, 1, 64'h0, 0},
        '{ntc_pkg::TY_F64, ntc_pkg::TY_I64, 64'h7FF0_0000_0000_0000, 1,
          64'h7FFF_FFFF_FFFF_FFFF, 0},
        '{ntc_pkg::TY_F64, ntc_pkg::TY_I64, 64'hFFF0_0000_0000_0000, 1,
          64'h8000_0000_0000_0000, 0},
        '{ntc_pkg::TY_F32, ntc_pkg::TY_U16, 64'hBF80_0000, 1, 64'h0, 0},
        '{ntc_pkg::TY_F32, ntc_pkg::TY_F64, 64'h8000_0000, 1, 64'h8000_0000_0000_0000, 0},
        '{ntc_pkg::TY_F64, ntc_pkg::TY_F32, 64'h7FF8_0000_0000_0001, 0, 0, 0},
        '{ntc_pkg::TY_F32, ntc_pkg::TY_F64, 64'hFFBF_FFFF, 0, 0, 0},
        '{ntc_pkg::TY_U64, ntc_pkg::TY_F32, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0},
        '{ntc_pkg::TY_I64, ntc_pkg::TY_F64, 64'h8000_0000_0000_0000, 0, 0, 0},
        '{ntc_pkg::TY_U64, ntc_pkg::TY_F64, 64'h0020_0000_0000_0001, 0, 0, 0},
        '{ntc_pkg::TY_F64, ntc_pkg::TY_F32, 64'h3690_0000_0000_0000, 0, 0, 0},
        '{ntc_pkg::TY_F64, ntc_pkg::TY_F32, 64'h47EF_FFFF_F000_0000, 0, 0, 0},
        '{ntc_pkg::TY_F32, ntc_pkg::TY_I8,  64'hC300_0000, 0, 0, 0},
        '{ntc_pkg::TY_F64, ntc_pkg::TY_U32, 64'h0000_0000_0000_0001, 0, 0, 0},
        '{ntc_pkg::TY_I16, ntc_pkg::TY_F32, 64'hFFFF_FFFF_FFFF_8000, 0, 0, 0},
        '{ntc_pkg::TY_F32, ntc_pkg::TY_I64, 64'h5F00_0000, 0, 0, 0}
    };

    // Random float-ish words with interesting exponent fields.
    function automatic logic [63:0] rand_value(logic [3:0] s);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = v >> $urandom_range(0, 63);
            1: v = -(v >> $urandom_range(0, 63));
            2: if (s == ntc_pkg::TY_F32) v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               else v[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
            3: if (s == ntc_pkg::TY_F32) v[30:23] = 8'($urandom_range(100, 200));
               else v[62:52] = 11'($urandom_range(850, 1250));
            default: ;
        endcase
        return v;
    endfunction

    // Drive one transaction on the falling edge and hold until accepted.
    task automatic send(logic [3:0] s, logic [3:0] d, logic [63:0] v);
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.src_type <= s;
        in_ch.dest_type <= d;
        in_ch.value_bits <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_q.push_back(convert(s, d, v));
    endtask

    task automatic gap();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    // Receiver: a stall pattern of its own, plus one long hold-off.
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (60) @(negedge i_clk);
                long_hold = 0;
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    // Checker and watchdog, both sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                idle_cycles <= 0;
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h bad %b", out_ch.result_bits,
                                 out_ch.bad_request);
                end else begin
                    t_conv want;
                    want = pending_q.pop_front();
                    if (want.res !== out_ch.result_bits || want.bad !== out_ch.bad_request) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h bad %b, got %h bad %b", want.res,
                                     want.bad, out_ch.result_bits, out_ch.bad_request);
                    end
                end
            end else if (in_ch.valid && in_ch.ready) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= ntc_tb_pkg::WATCHDOG_CYCLES) timed_out = 1;
            end
        end
    end

    initial begin
        int n;
        logic [3:0] s, d;
        in_ch.valid = 1'b0;
        in_ch.src_type = '0;
        in_ch.dest_type = '0;
        in_ch.value_bits = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Directed table; hand-typed rows must also agree with the predictor.
        foreach (dir_tbl[k]) begin
            if (dir_tbl[k].known) begin
                t_conv c;
                c = convert(dir_tbl[k].src, dir_tbl[k].dst, dir_tbl[k].val);
                if (c.res !== dir_tbl[k].res || c.bad !== dir_tbl[k].bad) begin
                    mismatches++;
                    $display("table row %0d disagrees with predictor", k);
                end
            end
            send(dir_tbl[k].src, dir_tbl[k].dst, dir_tbl[k].val);
        end
        // Random bursts; the long hold-off is triggered partway through.
        n = 0;
        while (n < 1900) begin
            repeat ($urandom_range(1, 20)) begin
                s = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, 9));
                d = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, 9));
                send(s, d, rand_value(s));
                n++;
                if (n == 500) long_hold = 1;
            end
            if ($urandom_range(0, 3) != 0) gap();
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done || timed_out);
        wait (pending_q.size() == 0 || timed_out);
        repeat (20) @(posedge i_clk);
        if (timed_out) begin
            $display("CHECKS FAILED");
        end else if (mismatches == 0 && pending_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== numeric_type_converter_top.f =====
hw/rtl/ntc_pkg.sv
hw/rtl/ntc_if.sv
hw/rtl/ntc_decode.sv
hw/rtl/ntc_normalize.sv
hw/rtl/ntc_round.sv
hw/rtl/ntc_pack.sv
hw/rtl/numeric_type_converter_top.sv
dv/ntc_tb_if.sv
dv/numeric_type_converter_top_tb.sv
